// ----- hw/rtl/pale_pkg.sv -----
// shared constants and types for the positional array list engine
package pale_pkg;

	localparam int PALE_CAPACITY = 128;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_FINAL = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic capture;
		logic start;
		logic scan;
		logic commit;
		logic load_out;
	} pale_cmd_t;

	typedef struct packed {
		logic go_scan;
		logic scan_done;
		logic out_free;
	} pale_sts_t;

endpackage

// ----- hw/rtl/pale_ram.sv -----
// generic simple dual-port ram with registered read
module pale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/pale_controller.sv -----
// control state machine sequencing one operation at a time
module pale_controller import pale_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pale_sts_t sts,
	output pale_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.start = 1'b1;
				state_d   = sts.go_scan ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/pale_datapath.sv -----
// list storage, count, shift and search sequencing, result register
module pale_datapath import pale_pkg::*; #(
	parameter int CAPACITY = PALE_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pale_cmd_t          cmd,
	output pale_sts_t          sts,
	input  logic [1:0]         opcode,
	input  logic [7:0]         position,
	input  logic signed [31:0] value,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic               found,
	output logic [7:0]         match_position,
	output logic [7:0]         entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int XW = ((CW > 8) ? CW : 8) + 1;

	logic [1:0]    op_q;
	logic [7:0]    pos_q;
	logic [31:0]   val_q;
	logic [CW-1:0] count_q;
	logic          ok_q;
	logic [1:0]    res_status_q;
	logic          res_found_q;
	logic [7:0]    res_mpos_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] rd_addr_q;
	logic          pend_s1;
	logic [AW-1:0] addr_s1;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic          out_found_q;
	logic [7:0]    out_mpos_q;
	logic [7:0]    out_count_q;

	logic [XW-1:0] pos_x, cnt_x, addr_x, moves_x, start_x;
	logic [1:0]    chk_status;
	logic          chk_ok;
	logic          issue;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [31:0]   rd_data;
	logic          hit;

	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(count_q);
	assign addr_x = XW'(addr_s1);

	// range and capacity checks, shift length and first address
	always_comb begin
		chk_status = ST_OK;
		chk_ok     = 1'b0;
		moves_x    = '0;
		start_x    = '0;
		case (op_q)
			OP_INSERT: begin
				moves_x = cnt_x - pos_x + XW'(1);
				start_x = cnt_x - XW'(1);
				if (cnt_x == XW'(CAPACITY)) begin
					chk_status = ST_FULL;
				end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
					chk_status = ST_RANGE;
				end else begin
					chk_ok = 1'b1;
				end
			end
			OP_DELETE: begin
				moves_x = cnt_x - pos_x;
				start_x = pos_x;
				if (pos_x == '0 || pos_x > cnt_x) begin
					chk_status = ST_RANGE;
				end else begin
					chk_ok = 1'b1;
				end
			end
			OP_SEARCH: begin
				moves_x = cnt_x;
				chk_ok  = 1'b1;
			end
			default: begin
				chk_ok = 1'b0;
			end
		endcase
	end

	assign issue = cmd.scan && (rem_q != '0) && !res_found_q;
	assign hit   = pend_s1 && (op_q == OP_SEARCH) && !res_found_q && (rd_data == val_q);

	// shift writes during the scan, new value written on commit
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = rd_data;
		if (pend_s1 && op_q == OP_INSERT) begin
			wr_en   = 1'b1;
			wr_addr = AW'(addr_x + XW'(1));
		end else if (pend_s1 && op_q == OP_DELETE) begin
			wr_en   = 1'b1;
			wr_addr = AW'(addr_x - XW'(1));
		end else if (cmd.commit && ok_q && op_q == OP_INSERT) begin
			wr_en   = 1'b1;
			wr_addr = AW'(pos_x - XW'(1));
			wr_data = val_q;
		end
	end

	pale_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			pos_q <= position;
			val_q <= value;
		end
		addr_s1 <= rd_addr_q;
		if (cmd.start) begin
			rd_addr_q    <= AW'(start_x);
			res_status_q <= chk_status;
			res_mpos_q   <= '0;
		end else if (issue) begin
			rd_addr_q <= (op_q == OP_INSERT) ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
		end
		if (hit) begin
			res_mpos_q <= 8'(addr_x + XW'(1));
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_mpos_q   <= res_mpos_q;
			out_count_q  <= 8'(cnt_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ok_q        <= 1'b0;
			res_found_q <= 1'b0;
			rem_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (cmd.start) begin
				ok_q        <= chk_ok;
				res_found_q <= 1'b0;
				rem_q       <= chk_ok ? CW'(moves_x) : '0;
			end else if (issue) begin
				rem_q <= rem_q - CW'(1);
			end
			if (hit) begin
				res_found_q <= 1'b1;
			end
			if (cmd.commit && ok_q && op_q == OP_INSERT) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.commit && ok_q && op_q == OP_DELETE) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.go_scan   = chk_ok;
	assign sts.scan_done = ((rem_q == '0) || res_found_q) && !pend_s1;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign found          = out_found_q;
	assign match_position = out_mpos_q;
	assign entry_count    = out_count_q;

endmodule

// ----- hw/rtl/positional_array_list_engine.sv -----
// top level: ordered list with positional insert, delete and linear search
// the scan issues its ram reads one per cycle
// one operation in flight; the next word is accepted the cycle after the result is registered
// reset clears the count and control; list storage is undefined until written
module positional_array_list_engine import pale_pkg::*; #(
	parameter int CAPACITY = PALE_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [7:0]         position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic               found,
	output logic [7:0]         match_position,
	output logic [7:0]         entry_count
);

	pale_cmd_t cmd;
	pale_sts_t sts;

	pale_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pale_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.position       (position),
		.value          (value),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.status         (status),
		.found          (found),
		.match_position (match_position),
		.entry_count    (entry_count)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted while an operation is in progress");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_OK)
		else $error("search hit reported with an error status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == CAPACITY[7:0])
		else $error("list full reported with a count below capacity");

endmodule
